[design/stm_pkg.sv]
package stm_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned RATE_W  = 20;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned DUTY_W  = 6;
  localparam int unsigned PHASE_W = 6;

  // One second in microsecond ticks, the dividend of the delay division
  localparam logic [RATE_W-1:0] UsecPerSec = 20'd1000000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_STEP      = 2'd0,
    KIND_STOPPED   = 2'd1,
    KIND_BUSY      = 2'd2,
    KIND_ZERO_RATE = 2'd3
  } kind_e;

  // Quarter-cosine duty curve over 64 positions; the four coil pins read it
  // at offsets 0, 32, 48 and 16. Shorter tables take every 2nd or 4th entry.
  localparam logic [DUTY_W-1:0] CURVE [64] = '{
    6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50,
    6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50,
    6'd50, 6'd45, 6'd40, 6'd36, 6'd31, 6'd27, 6'd22, 6'd19,
    6'd15, 6'd12, 6'd9,  6'd6,  6'd4,  6'd2,  6'd1,  6'd0,
    6'd0,  6'd0,  6'd1,  6'd2,  6'd4,  6'd6,  6'd9,  6'd12,
    6'd15, 6'd19, 6'd22, 6'd27, 6'd31, 6'd36, 6'd40, 6'd45,
    6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50,
    6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50
  };

  localparam logic [PHASE_W-1:0] OFS_COS1 = 6'd0;
  localparam logic [PHASE_W-1:0] OFS_COS2 = 6'd32;
  localparam logic [PHASE_W-1:0] OFS_SIN1 = 6'd48;
  localparam logic [PHASE_W-1:0] OFS_SIN2 = 6'd16;

endpackage

[design/stepper_microstep_sequencer.sv]
// Microstep sequencer for a two-coil stepper. A start transfer with a
// nonzero rate and count runs a restoring divider for 1000000/rate, one
// quotient bit per cycle; its last step loads the first microstep result.
// Other transfers (tick, stop, rejected or empty start, unknown code) skip
// the divider. Each microstep result holds four duties from a 64-entry
// quarter cosine curve at the running phase; further microsteps follow on
// tick transfers once the delay count runs out. One output register holds
// the result; the input stalls while the divider runs or while that
// register is full and stalled.
module stepper_microstep_sequencer #(
  parameter int unsigned MICROSTEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [stm_pkg::FUNC_W-1:0]    func_i,
  input  logic [stm_pkg::RATE_W-1:0]    rate_pps_i,
  input  logic [stm_pkg::COUNT_W-1:0]   step_count_i,
  input  logic                          direction_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [stm_pkg::KIND_W-1:0]    kind_o,
  output logic [stm_pkg::DUTY_W-1:0]    duty_a1_o,
  output logic [stm_pkg::DUTY_W-1:0]    duty_a2_o,
  output logic [stm_pkg::DUTY_W-1:0]    duty_b1_o,
  output logic [stm_pkg::DUTY_W-1:0]    duty_b2_o,
  output logic [stm_pkg::PHASE_W-1:0]   table_phase_o,
  output logic                          last_o
);
  import stm_pkg::*;

  localparam int unsigned TabLen   = (MICROSTEPS < 8) ? 16 : ((MICROSTEPS < 16) ? 32 : 64);
  localparam int unsigned PosW     = $clog2(TabLen);
  localparam int unsigned TabShift = PHASE_W - PosW;
  localparam int unsigned CntW     = $clog2(RATE_W);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_e;

  state_e               state_q, state_d;
  logic                 mount_q;
  logic [PosW-1:0]      phase_q, phase_d;
  logic                 running_q, running_d;
  logic [COUNT_W-1:0]   steps_left_q, steps_left_d;
  logic [DELAY_W-1:0]   reload_q, reload_d;
  logic [DELAY_W-1:0]   delay_left_q, delay_left_d;
  logic                 swap_q, swap_d;

  logic [RATE_W-1:0]    divisor_q, divisor_d;
  logic [RATE_W-1:0]    rem_q, rem_d;
  logic [RATE_W-1:0]    quo_q, quo_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [RATE_W:0]      trial;
  logic                 qbit;

  logic                 out_valid_q, out_valid_d;
  kind_e                kind_q;
  logic [DUTY_W-1:0]    duty_a1_q, duty_a2_q, duty_b1_q, duty_b2_q;
  logic [PHASE_W-1:0]   phase_out_q;
  logic                 last_q;

  logic                 in_accept;
  logic                 res_load;
  logic                 do_step;
  kind_e                res_kind;
  logic [DELAY_W-1:0]   step_reload;

  logic [PHASE_W-1:0]   base_idx;
  logic [DUTY_W-1:0]    cos1, cos2, sin1, sin2;

  assign in_stall_o = (state_q == ST_DIV) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Restoring divider: shift in one dividend bit, subtract when it fits
  assign trial = {rem_q, quo_q[RATE_W-1]};
  assign qbit  = (trial >= {1'b0, divisor_q});

  assign base_idx = PHASE_W'(phase_q) << TabShift;
  assign cos1 = CURVE[base_idx + OFS_COS1];
  assign cos2 = CURVE[base_idx + OFS_COS2];
  assign sin1 = CURVE[base_idx + OFS_SIN1];
  assign sin2 = CURVE[base_idx + OFS_SIN2];

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    running_d    = running_q;
    steps_left_d = steps_left_q;
    reload_d     = reload_q;
    delay_left_d = delay_left_q;
    swap_d       = swap_q;
    divisor_d    = divisor_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    res_load     = 1'b0;
    res_kind     = KIND_STEP;
    do_step      = 1'b0;
    step_reload  = reload_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (func_e'(func_i))
            FUNC_START: begin
              if (running_q) begin
                res_load = 1'b1;
                res_kind = KIND_BUSY;
              end else if (rate_pps_i == '0) begin
                res_load = 1'b1;
                res_kind = KIND_ZERO_RATE;
              end else if (step_count_i != '0) begin
                steps_left_d = step_count_i;
                swap_d       = direction_i ^ mount_q;
                divisor_d    = rate_pps_i;
                rem_d        = '0;
                quo_d        = UsecPerSec;
                cnt_d        = '0;
                state_d      = ST_DIV;
              end
            end
            FUNC_TICK: begin
              if (running_q) begin
                if (delay_left_q > DELAY_W'(1)) begin
                  delay_left_d = delay_left_q - DELAY_W'(1);
                end else begin
                  delay_left_d = '0;
                  if (steps_left_q == '0) begin
                    running_d = 1'b0;
                  end else begin
                    do_step = 1'b1;
                  end
                end
              end
            end
            FUNC_STOP: begin
              running_d    = 1'b0;
              steps_left_d = '0;
              delay_left_d = '0;
              res_load     = 1'b1;
              res_kind     = KIND_STOPPED;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        rem_d = qbit ? RATE_W'(trial - {1'b0, divisor_q}) : trial[RATE_W-1:0];
        quo_d = {quo_q[RATE_W-2:0], qbit};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(RATE_W - 1)) begin
          // Saturate the quotient to the delay width and emit the first microstep
          step_reload = (|quo_d[RATE_W-1:DELAY_W]) ? '1 : quo_d[DELAY_W-1:0];
          reload_d    = step_reload;
          running_d   = 1'b1;
          do_step     = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (do_step) begin
      res_load     = 1'b1;
      res_kind     = KIND_STEP;
      steps_left_d = steps_left_q - COUNT_W'(1);
      phase_d      = phase_q + PosW'(1);
      delay_left_d = step_reload;
    end
    if (res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mount_q      <= 1'b0;
      phase_q      <= '0;
      running_q    <= 1'b0;
      steps_left_q <= '0;
      reload_q     <= '0;
      delay_left_q <= '0;
      swap_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        mount_q <= cfg_wdata_i;
      end
      phase_q      <= phase_d;
      running_q    <= running_d;
      steps_left_q <= steps_left_d;
      reload_q     <= reload_d;
      delay_left_q <= delay_left_d;
      swap_q       <= swap_d;
      out_valid_q  <= out_valid_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    if (res_load) begin
      kind_q      <= res_kind;
      phase_out_q <= PHASE_W'(phase_q);
      last_q      <= do_step && (steps_left_q == COUNT_W'(1));
      if (do_step) begin
        duty_a1_q <= swap_q ? sin1 : cos1;
        duty_a2_q <= swap_q ? sin2 : cos2;
        duty_b1_q <= swap_q ? cos1 : sin1;
        duty_b2_q <= swap_q ? cos2 : sin2;
      end else begin
        duty_a1_q <= '0;
        duty_a2_q <= '0;
        duty_b1_q <= '0;
        duty_b2_q <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign duty_a1_o     = duty_a1_q;
  assign duty_a2_o     = duty_a2_q;
  assign duty_b1_o     = duty_b1_q;
  assign duty_b2_o     = duty_b2_q;
  assign table_phase_o = phase_out_q;
  assign last_o        = last_q;

  // The divider never finishes into a full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == CntW'(RATE_W - 1)) |-> !out_valid_q)
    else $error("divider finished while a result was pending");

  // No transfer is taken while the divider runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q != CntW'(RATE_W - 1)) |=>
      (state_q == ST_DIV && $stable(steps_left_q)))
    else $error("steps changed during division");

  // An idle sequencer holds no pending steps or delay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !running_q) |-> (steps_left_q == '0 && delay_left_q == '0))
    else $error("idle with pending steps or delay");

  // A final microstep leaves no steps behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_STEP && last_q) |-> (steps_left_q == '0))
    else $error("last microstep with steps left");

  // Rejections and stops carry zero duties
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q != KIND_STEP) |->
      (duty_a1_q == '0 && duty_b1_q == '0 && !last_q))
    else $error("nonzero duty on a non-step result");

endmodule

[dv/tb_stepper_microstep_sequencer.sv]
module tb_stepper_microstep_sequencer;
  import stm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned SHOW_ERRORS  = 10;

  // Quarter-cosine duty curve; the four pins read it at fixed phase offsets
  localparam logic [DUTY_W-1:0] DUTY_CURVE [64] = '{
    6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50,
    6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50,
    6'd50, 6'd45, 6'd40, 6'd36, 6'd31, 6'd27, 6'd22, 6'd19,
    6'd15, 6'd12, 6'd9,  6'd6,  6'd4,  6'd2,  6'd1,  6'd0,
    6'd0,  6'd0,  6'd1,  6'd2,  6'd4,  6'd6,  6'd9,  6'd12,
    6'd15, 6'd19, 6'd22, 6'd27, 6'd31, 6'd36, 6'd40, 6'd45,
    6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50,
    6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50
  };
  localparam logic [PHASE_W-1:0] SHIFT_COS2 = 6'd32;
  localparam logic [PHASE_W-1:0] SHIFT_SIN1 = 6'd48;
  localparam logic [PHASE_W-1:0] SHIFT_SIN2 = 6'd16;

  typedef struct packed {
    kind_e               kind;
    logic [DUTY_W-1:0]   a1;
    logic [DUTY_W-1:0]   a2;
    logic [DUTY_W-1:0]   b1;
    logic [DUTY_W-1:0]   b2;
    logic [PHASE_W-1:0]  phase;
    logic                last;
  } coil_duties_t;

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic                cfg_wdata_i  = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [FUNC_W-1:0]   func_i       = FUNC_NONE;
  logic [RATE_W-1:0]   rate_pps_i   = '0;
  logic [COUNT_W-1:0]  step_count_i = '0;
  logic                direction_i  = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [KIND_W-1:0]   kind_o;
  logic [DUTY_W-1:0]   duty_a1_o;
  logic [DUTY_W-1:0]   duty_a2_o;
  logic [DUTY_W-1:0]   duty_b1_o;
  logic [DUTY_W-1:0]   duty_b2_o;
  logic [PHASE_W-1:0]  table_phase_o;
  logic                last_o;

  stepper_microstep_sequencer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .rate_pps_i    (rate_pps_i),
    .step_count_i  (step_count_i),
    .direction_i   (direction_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .duty_a1_o     (duty_a1_o),
    .duty_a2_o     (duty_a2_o),
    .duty_b1_o     (duty_b1_o),
    .duty_b2_o     (duty_b2_o),
    .table_phase_o (table_phase_o),
    .last_o        (last_o)
  );

  // Shadow copy of the sequencer state
  logic                mount_q;
  logic [PHASE_W-1:0]  phase_q;
  logic                run_q;
  logic [COUNT_W-1:0]  left_q;
  logic [DELAY_W-1:0]  reload_q;
  logic [DELAY_W-1:0]  wait_q;
  logic                swap_q;

  coil_duties_t        pending_duties [$];
  int unsigned         error_cnt;
  int unsigned         items_sent;
  int unsigned         cycle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void queue_status(kind_e kind);
    coil_duties_t r;
    r       = '0;
    r.kind  = kind;
    r.phase = phase_q;
    pending_duties.push_back(r);
  endfunction

  function automatic void queue_microstep();
    coil_duties_t        r;
    logic [DUTY_W-1:0]   cos1, cos2, sin1, sin2;
    cos1 = DUTY_CURVE[phase_q];
    cos2 = DUTY_CURVE[phase_q + SHIFT_COS2];
    sin1 = DUTY_CURVE[phase_q + SHIFT_SIN1];
    sin2 = DUTY_CURVE[phase_q + SHIFT_SIN2];
    r.kind  = KIND_STEP;
    r.a1    = swap_q ? sin1 : cos1;
    r.a2    = swap_q ? sin2 : cos2;
    r.b1    = swap_q ? cos1 : sin1;
    r.b2    = swap_q ? cos2 : sin2;
    r.phase = phase_q;
    r.last  = (left_q == 1);
    pending_duties.push_back(r);
    left_q  = left_q - 1;
    phase_q = phase_q + 1'b1;
    wait_q  = reload_q;
  endfunction

  function automatic logic [31:0] delay_for(logic [RATE_W-1:0] rate);
    logic [31:0] quo;
    quo = 32'd1000000 / {12'd0, rate};
    return (quo > 32'd65535) ? 32'd65535 : quo;
  endfunction

  function automatic void advance_phase_tracker(func_e fn, logic [RATE_W-1:0] rate,
                                                logic [COUNT_W-1:0] cnt, logic dir);
    case (fn)
      FUNC_START: begin
        if (run_q) begin
          queue_status(KIND_BUSY);
        end else if (rate == 0) begin
          queue_status(KIND_ZERO_RATE);
        end else if (cnt != 0) begin
          reload_q = DELAY_W'(delay_for(rate));
          swap_q   = dir ^ mount_q;
          left_q   = cnt;
          run_q    = 1'b1;
          queue_microstep();
        end
      end
      FUNC_TICK: begin
        if (run_q) begin
          if (wait_q > 1) begin
            wait_q = wait_q - DELAY_W'(1);
          end else begin
            wait_q = '0;
            // Trailing delay over: drop out of the run silently
            if (left_q == 0) run_q = 1'b0;
            else queue_microstep();
          end
        end
      end
      FUNC_STOP: begin
        run_q  = 1'b0;
        left_q = '0;
        wait_q = '0;
        queue_status(KIND_STOPPED);
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_item(func_e fn, logic [RATE_W-1:0] rate, logic [COUNT_W-1:0] cnt,
                           logic dir);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= fn;
    rate_pps_i   <= rate;
    step_count_i <= cnt;
    direction_i  <= dir;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    advance_phase_tracker(fn, rate, cnt, dir);
    items_sent++;
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mount(logic value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mount_q = value;
  endtask

  function automatic void note_error(string msg);
    error_cnt++;
    if (error_cnt <= SHOW_ERRORS) $display("%s", msg);
  endfunction

  // Result checker
  initial begin : result_check
    coil_duties_t got, want;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        got = '{kind_e'(kind_o), duty_a1_o, duty_a2_o, duty_b1_o, duty_b2_o,
                table_phase_o, last_o};
        if (pending_duties.size() == 0) begin
          note_error($sformatf("unexpected result kind=%0d phase=%0d", kind_o,
                               table_phase_o));
        end else begin
          want = pending_duties.pop_front();
          if (got !== want)
            note_error($sformatf({"mismatch exp kind=%0d a1=%0d a2=%0d b1=%0d b2=%0d ",
                                  "phase=%0d last=%0d got kind=%0d a1=%0d a2=%0d b1=%0d ",
                                  "b2=%0d phase=%0d last=%0d"},
                                 want.kind, want.a1, want.a2, want.b1, want.b2, want.phase,
                                 want.last, got.kind, got.a1, got.a2, got.b1, got.b2,
                                 got.phase, got.last));
        end
      end
    end
  end

  // Receiver stalls: short bursts, a few long ones, and long clean stretches
  initial begin : sink_stall
    logic        stall_now;
    int unsigned hold;
    stall_now = 1'b0;
    hold      = 20;
    forever begin
      @(posedge clk_i);
      if (hold == 0) begin
        stall_now = ~stall_now;
        if (stall_now)
          hold = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        else
          hold = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 12) :
                                                 $urandom_range(50, 300);
      end else begin
        hold--;
      end
      out_stall_i <= stall_now;
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic test_directed();
    send_item(FUNC_TICK,  20'd500, 32'd7, 1'b0);            // tick while idle
    send_item(FUNC_STOP,  20'd0, 32'd0, 1'b0);              // stop while idle
    send_item(FUNC_NONE,  20'hFFFFF, 32'hFFFFFFFF, 1'b1);   // unknown code
    send_item(FUNC_START, 20'd0, 32'd5, 1'b0);              // zero rate
    send_item(FUNC_START, 20'd1000, 32'd0, 1'b1);           // zero count
    // Rate above one million: zero delay, one microstep per tick
    send_item(FUNC_START, 20'hFFFFF, 32'd3, 1'b0);
    repeat (3) send_item(FUNC_TICK, 20'd0, 32'd0, 1'b0);
    send_item(FUNC_START, 20'd1000000, 32'd2, 1'b1);
    send_item(FUNC_START, 20'd4000, 32'd9, 1'b0);           // busy
    repeat (2) send_item(FUNC_TICK, 20'd0, 32'd0, 1'b0);
    // Slowest rate saturates the delay; abort it with stop
    send_item(FUNC_START, 20'd1, 32'hFFFFFFFF, 1'b1);
    repeat (2) send_item(FUNC_TICK, 20'd0, 32'd0, 1'b0);
    send_item(FUNC_STOP, 20'hFFFFF, 32'hFFFFFFFF, 1'b1);
    // Delay of three, run out including the trailing delay
    send_item(FUNC_START, 20'd333333, 32'd2, 1'b0);
    repeat (6) send_item(FUNC_TICK, 20'd0, 32'd0, 1'b0);
    wait_drain();
  endtask

  task automatic test_random_runs(int unsigned n);
    int unsigned         stop_at, p, nt, eff, burst;
    logic [RATE_W-1:0]   rate;
    logic [COUNT_W-1:0]  cnt;
    logic                quick;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 70) begin
        // Clean run from idle with random content
        if (run_q) send_item(FUNC_STOP, RATE_W'($urandom), $urandom, 1'($urandom));
        p = $urandom_range(0, 99);
        if (p < 55)      rate = RATE_W'($urandom_range(250000, 20'hFFFFF));
        else if (p < 85) rate = RATE_W'($urandom_range(40000, 250000));
        else             rate = RATE_W'($urandom);
        cnt = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom;
        send_item(FUNC_START, rate, cnt, 1'($urandom));
        eff   = (rate == 0) ? 1 : ((delay_for(rate) == 0) ? 1 : delay_for(rate));
        quick = (cnt <= 8) && (eff <= 25);
        nt    = quick ? eff * cnt + $urandom_range(0, 2) : $urandom_range(1, 8);
        repeat (nt) begin
          p = $urandom_range(0, 99);
          if (p < 4)
            send_item(FUNC_START, RATE_W'($urandom), $urandom_range(0, 4), 1'($urandom));
          else if (p < 7)
            send_item(FUNC_NONE, RATE_W'($urandom), $urandom, 1'($urandom));
          else
            send_item(FUNC_TICK, RATE_W'($urandom), $urandom, 1'($urandom));
        end
        if (run_q && (!quick || $urandom_range(0, 9) == 0))
          send_item(FUNC_STOP, RATE_W'($urandom), $urandom, 1'($urandom));
      end else begin
        // Noise and broken sequences
        burst = $urandom_range(1, 4);
        repeat (burst)
          send_item(func_e'($urandom_range(0, 3)), RATE_W'($urandom),
                    ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 3),
                    1'($urandom));
        if (run_q && $urandom_range(0, 1) == 1)
          send_item(FUNC_STOP, RATE_W'($urandom), $urandom, 1'($urandom));
      end
    end
    wait_drain();
  endtask

  initial begin : main
    mount_q    = 1'b0;
    phase_q    = '0;
    run_q      = 1'b0;
    left_q     = '0;
    reload_q   = '0;
    wait_q     = '0;
    swap_q     = 1'b0;
    error_cnt  = 0;
    items_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    write_mount(1'b1);
    test_random_runs(130);
    write_mount(1'b0);
    test_random_runs(130);
    write_mount(1'b1);
    test_random_runs(140);

    while (pending_duties.size() != 0) begin
      note_error($sformatf("missing result kind=%0d phase=%0d",
                           pending_duties[0].kind, pending_duties[0].phase));
      void'(pending_duties.pop_front());
    end
    if (error_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[stepper_microstep_sequencer.f]
design/stm_pkg.sv
design/stepper_microstep_sequencer.sv
dv/tb_stepper_microstep_sequencer.sv
